// ===== rtl/pfn_pkg.sv =====
// ----------------------------------------------------------------------------
// pfn_pkg: shared constants of the polygon face normal block
// Output field width, saturation bounds and the magnitude limit of a latched raw normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfn_pkg;

   // Signed width of one scaled normal component.
   localparam int OUT_W = 17;

   // A latched raw normal component keeps a magnitude below 2^MAG_W.
   localparam int MAG_W = 33;

   // Saturation bounds of a scaled component.
   localparam int OUT_POS_MAX = 65535;
   localparam int OUT_NEG_MAX = 65536;

endpackage

// ===== rtl/pfn_req_if.sv =====
// ----------------------------------------------------------------------------
// pfn_req_if: vertex channel
// Valid/ready channel that moves one polygon vertex per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfn_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] vertex_z;
   logic                          last_vertex;
   logic                          force_visible;

   modport source (
      output valid, vertex_x, vertex_y, vertex_z, last_vertex, force_visible,
      input  ready
   );
   modport sink (
      input  valid, vertex_x, vertex_y, vertex_z, last_vertex, force_visible,
      output ready
   );
endinterface

// ===== rtl/pfn_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfn_rsp_if: normal channel
// Valid/ready channel that moves one scaled face normal per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfn_rsp_if;
   import pfn_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] normal_x;
   logic signed [OUT_W-1:0] normal_y;
   logic signed [OUT_W-1:0] normal_z;
   logic                    always_visible;

   modport source (
      output valid, normal_x, normal_y, normal_z, always_visible,
      input  ready
   );
   modport sink (
      input  valid, normal_x, normal_y, normal_z, always_visible,
      output ready
   );
endinterface

// ===== rtl/polygon_face_normal_top.sv =====
// ----------------------------------------------------------------------------
// polygon_face_normal_top: face normal of a streamed polygon
// A vertex that completes a window without a latched normal runs the cross product
// on the shared multiplier, then halves the normal until it fits (never needed at
// 16 bits). The last vertex adds the squares and, per component, the bit-serial
// scale, divide and root loops.
// Synchronous reset clears control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_face_normal_top #(
   parameter int COORD_WIDTH   = 16,
   parameter int NORMAL_LENGTH = 2048
) (
   input  logic      clock,
   input  logic      reset,
   pfn_req_if.sink   req_chan,
   pfn_rsp_if.source rsp_chan
);
   import pfn_pkg::*;

   // ------------------------------------------------------------------------
   // Derived widths
   // ------------------------------------------------------------------------
   // DW: coordinate difference, PW: one product, CPW: one cross component.
   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * DW;
   localparam int CPW = PW + 1;
   // MGW: magnitude register wide enough for a raw cross component and the
   // reduction test on bits at and above MAG_W.
   localparam int MGW = (CPW > MAG_W + 1) ? CPW : MAG_W + 1;
   // MW: operand width of the shared signed multiplier.
   localparam int MW  = (DW > MAG_W + 1) ? DW : MAG_W + 1;
   // SQW: square of one magnitude, SW: sum of three squares.
   localparam int SQW = 2 * MAG_W;
   localparam int SW  = SQW + 2;
   // Scale constant: the component is compared as t^2 * S <= C * m^2
   // with C = 4 * (16 * NORMAL_LENGTH)^2.
   localparam longint unsigned KSCALE = 64'(NORMAL_LENGTH) * 64'd16;
   localparam longint unsigned CSCALE = 64'd4 * KSCALE * KSCALE;
   localparam int CB  = $clog2(CSCALE + 64'd1);
   // NW: dividend C * m^2, QW: quotient, H: root digits.
   localparam int NW  = SQW + CB;
   localparam int QW  = CB;
   localparam int H   = (QW + 1) / 2;
   localparam int ITW = $clog2(NW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CROSS,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULC,
      ST_DIVIDE,
      ST_ROOT,
      ST_DONE
   } state_type;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type                state_ff;
   logic [2:0]               step_ff;
   logic [1:0]               comp_ff;
   logic [ITW-1:0]           it_ff;

   // Sliding window of the two previous vertices.
   logic signed [COORD_WIDTH-1:0] older_ff [3];
   logic signed [COORD_WIDTH-1:0] newer_ff [3];
   logic [1:0]               count_ff;
   logic                     found_ff;
   logic                     last_ff;
   logic                     force_ff;

   // Cross product operands and results.
   logic signed [DW-1:0]     a_ff [3];
   logic signed [DW-1:0]     b_ff [3];
   logic signed [2*MW-1:0]   prod_ff;
   logic signed [PW-1:0]     acc_ff;
   logic signed [CPW-1:0]    c_ff [3];

   // Latched normal as sign and magnitude.
   logic [MGW-1:0]           mag_ff [3];
   logic                     sign_ff [3];
   logic [MAG_W-1:0]         raw_ff [3];

   // Scaling datapath.
   logic [SQW-1:0]           sq_ff [3];
   logic [SW-1:0]            sum_ff;
   logic [CB-1:0]            cshift_ff;
   logic [NW-1:0]            n_ff;
   logic [SW-1:0]            rem_ff;
   logic [QW-1:0]            q_ff;
   logic [2*H-1:0]           rad_ff;
   logic [H+1:0]             srem_ff;
   logic [H-1:0]             root_ff;
   logic signed [OUT_W-1:0]  outc_ff [3];

   // Result register.
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_x_ff;
   logic signed [OUT_W-1:0]  rsp_y_ff;
   logic signed [OUT_W-1:0]  rsp_z_ff;
   logic                     rsp_vis_ff;

   // ------------------------------------------------------------------------
   // Combinational datapath
   // ------------------------------------------------------------------------
   logic                     req_fire;
   logic                     rsp_fire;
   logic                     out_free;
   logic signed [COORD_WIDTH-1:0] cur_v [3];
   logic signed [MW-1:0]     mul_a;
   logic signed [MW-1:0]     mul_b;
   logic signed [CPW-1:0]    prod_c;
   logic signed [CPW-1:0]    acc_c;
   logic                     c_zero;
   logic                     mag_high;
   logic [NW-1:0]            n_in;
   logic [SW:0]              rem_t;
   logic                     div_ge;
   logic [SW-1:0]            rem_in;
   logic [QW-1:0]            q_in;
   logic [H+3:0]             rt;
   logic [H+3:0]             trial;
   logic                     root_ge;
   logic [H+1:0]             srem_in;
   logic [H-1:0]             root_in;
   logic [H:0]               lo;
   int                       lo_int;
   logic signed [OUT_W-1:0]  scaled;

   assign cur_v[0] = req_chan.vertex_x;
   assign cur_v[1] = req_chan.vertex_y;
   assign cur_v[2] = req_chan.vertex_z;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Shared multiplier operand select: six cross products, then three squares.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CROSS) begin
         unique case (step_ff)
            3'd0: begin mul_a = MW'(a_ff[1]); mul_b = MW'(b_ff[2]); end
            3'd1: begin mul_a = MW'(a_ff[2]); mul_b = MW'(b_ff[1]); end
            3'd2: begin mul_a = MW'(a_ff[2]); mul_b = MW'(b_ff[0]); end
            3'd3: begin mul_a = MW'(a_ff[0]); mul_b = MW'(b_ff[2]); end
            3'd4: begin mul_a = MW'(a_ff[0]); mul_b = MW'(b_ff[1]); end
            3'd5: begin mul_a = MW'(a_ff[1]); mul_b = MW'(b_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_SQUARE && step_ff < 3'd3) begin
         mul_a = $signed({1'b0, raw_ff[step_ff[1:0]]});
         mul_b = $signed({1'b0, raw_ff[step_ff[1:0]]});
      end
   end

   assign prod_c = CPW'($signed(prod_ff[PW-1:0]));
   assign acc_c  = CPW'(acc_ff);

   assign c_zero   = (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
   assign mag_high = (|mag_ff[0][MGW-1:MAG_W]) || (|mag_ff[1][MGW-1:MAG_W])
                   || (|mag_ff[2][MGW-1:MAG_W]);

   // Serial multiply by the scale constant, MSB first.
   assign n_in = {n_ff[NW-2:0], 1'b0}
               + (cshift_ff[CB-1] ? NW'(sq_ff[comp_ff]) : NW'(0));

   // Restoring division of C * m^2 by the sum of squares.
   assign rem_t  = {rem_ff, n_ff[NW-1]};
   assign div_ge = rem_t >= {1'b0, sum_ff};
   assign rem_in = div_ge ? SW'(rem_t - {1'b0, sum_ff}) : SW'(rem_t);
   assign q_in   = {q_ff[QW-2:0], div_ge};

   // Digit-by-digit integer square root of the quotient.
   assign rt      = {srem_ff, rad_ff[2*H-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign root_ge = rt >= trial;
   assign srem_in = root_ge ? (H+2)'(rt - trial) : (H+2)'(rt);
   assign root_in = {root_ff[H-2:0], root_ge};

   // Largest odd t with t*t under the quotient gives lo = (root + 1) / 2.
   assign lo     = ({1'b0, root_in} + (H+1)'(1)) >> 1;
   assign lo_int = int'(lo);

   always_comb begin
      if (sign_ff[comp_ff]) begin
         scaled = (lo_int > OUT_NEG_MAX) ? OUT_W'(-OUT_NEG_MAX) : OUT_W'(-lo_int);
      end else begin
         scaled = (lo_int > OUT_POS_MAX) ? OUT_W'(OUT_POS_MAX) : OUT_W'(lo_int);
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer, datapath registers and result register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         comp_ff      <= '0;
         it_ff        <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            older_ff[i] <= '0;
            newer_ff[i] <= '0;
         end
      end else begin
         // Raise valid when the done step loads a result, drop it on accept.
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         // Multiplier output register, used by the cross and square steps.
         prod_ff <= mul_a * mul_b;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  last_ff  <= req_chan.last_vertex;
                  force_ff <= req_chan.force_visible;
                  // Take the differences against the oldest vertex before
                  // the window moves on.
                  for (int i = 0; i < 3; i++) begin
                     a_ff[i] <= DW'(newer_ff[i]) - DW'(older_ff[i]);
                     b_ff[i] <= DW'(cur_v[i]) - DW'(older_ff[i]);
                  end
                  // Advance the window; a last vertex clears it for the
                  // next polygon.
                  for (int i = 0; i < 3; i++) begin
                     older_ff[i] <= req_chan.last_vertex ? '0 : newer_ff[i];
                     newer_ff[i] <= req_chan.last_vertex ? '0 : cur_v[i];
                  end
                  if (req_chan.last_vertex) begin
                     count_ff <= '0;
                  end else if (count_ff != 2'd3) begin
                     count_ff <= count_ff + 2'd1;
                  end
                  step_ff <= '0;
                  if (count_ff >= 2'd2 && !found_ff) begin
                     state_ff <= ST_CROSS;
                  end else if (req_chan.last_vertex) begin
                     state_ff <= found_ff ? ST_SQUARE : ST_DONE;
                  end
               end
            end

            ST_CROSS: begin
               // Products land in prod_ff in the cycle after their operands are selected.
               if (step_ff != 3'd0) begin
                  if (!step_ff[0]) begin
                     c_ff[step_ff[2:1] - 2'd1] <= acc_c - prod_c;
                  end else begin
                     acc_ff <= $signed(prod_ff[PW-1:0]);
                  end
               end
               if (step_ff == 3'd6) begin
                  step_ff  <= '0;
                  state_ff <= ST_REDUCE;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end

            ST_REDUCE: begin
               if (step_ff == 3'd0) begin
                  for (int i = 0; i < 3; i++) begin
                     sign_ff[i] <= c_ff[i][CPW-1];
                     mag_ff[i]  <= c_ff[i][CPW-1] ? MGW'(-c_ff[i]) : MGW'(c_ff[i]);
                  end
                  if (c_zero) begin
                     // Collinear window: keep looking on later vertices.
                     state_ff <= last_ff ? ST_DONE : ST_IDLE;
                  end else begin
                     step_ff <= 3'd1;
                  end
               end else if (mag_high) begin
                  // Halve all three until every magnitude fits.
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] >> 1;
                  end
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     raw_ff[i] <= mag_ff[i][MAG_W-1:0];
                  end
                  found_ff <= 1'b1;
                  step_ff  <= '0;
                  state_ff <= last_ff ? ST_SQUARE : ST_IDLE;
               end
            end

            ST_SQUARE: begin
               if (step_ff != 3'd0) begin
                  sq_ff[step_ff[1:0] - 2'd1] <= prod_ff[SQW-1:0];
                  if (step_ff == 3'd1) begin
                     sum_ff <= SW'(prod_ff[SQW-1:0]);
                  end else begin
                     sum_ff <= sum_ff + SW'(prod_ff[SQW-1:0]);
                  end
               end
               if (step_ff == 3'd3) begin
                  step_ff   <= '0;
                  comp_ff   <= '0;
                  it_ff     <= '0;
                  n_ff      <= '0;
                  cshift_ff <= CB'(CSCALE);
                  state_ff  <= ST_MULC;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end

            ST_MULC: begin
               n_ff      <= n_in;
               cshift_ff <= cshift_ff << 1;
               if (it_ff == ITW'(CB - 1)) begin
                  it_ff    <= '0;
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  state_ff <= ST_DIVIDE;
               end else begin
                  it_ff <= it_ff + ITW'(1);
               end
            end

            ST_DIVIDE: begin
               rem_ff <= rem_in;
               q_ff   <= q_in;
               n_ff   <= n_ff << 1;
               if (it_ff == ITW'(NW - 1)) begin
                  it_ff    <= '0;
                  rad_ff   <= (2*H)'(q_in);
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  it_ff <= it_ff + ITW'(1);
               end
            end

            ST_ROOT: begin
               srem_ff <= srem_in;
               root_ff <= root_in;
               rad_ff  <= rad_ff << 2;
               if (it_ff == ITW'(H - 1)) begin
                  it_ff            <= '0;
                  outc_ff[comp_ff] <= scaled;
                  if (comp_ff == 2'd2) begin
                     state_ff <= ST_DONE;
                  end else begin
                     comp_ff   <= comp_ff + 2'd1;
                     n_ff      <= '0;
                     cshift_ff <= CB'(CSCALE);
                     state_ff  <= ST_MULC;
                  end
               end else begin
                  it_ff <= it_ff + ITW'(1);
               end
            end

            ST_DONE: begin
               // Hold until the result register is free, then drop the
               // latched normal for the next polygon.
               if (out_free) begin
                  if (found_ff) begin
                     rsp_x_ff   <= outc_ff[0];
                     rsp_y_ff   <= outc_ff[1];
                     rsp_z_ff   <= outc_ff[2];
                     rsp_vis_ff <= force_ff;
                  end else begin
                     rsp_x_ff   <= '0;
                     rsp_y_ff   <= '0;
                     rsp_z_ff   <= '0;
                     rsp_vis_ff <= 1'b1;
                  end
                  found_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.normal_x       = rsp_x_ff;
   assign rsp_chan.normal_y       = rsp_y_ff;
   assign rsp_chan.normal_z       = rsp_z_ff;
   assign rsp_chan.always_visible = rsp_vis_ff;

`ifndef SYNTHESIS
   a_last_clears_count : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.last_vertex) |=> (count_ff == 2'd0))
      else $error("vertex count not cleared after last vertex");

   a_found_needs_window : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && found_ff) |-> (count_ff >= 2'd2))
      else $error("normal latched with fewer than three vertices");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done step");

   a_div_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < sum_ff))
      else $error("division remainder out of range");
`endif

endmodule
